FILE: hdl/magnetometer_iron_correct_average_unit_macros.svh
// Assertion macros for the magnetometer iron correction and averaging unit.
// Included by the top level; expects signals clk and rst_n in scope.
`ifndef MAGNETOMETER_IRON_CORRECT_AVERAGE_UNIT_MACROS_SVH
`define MAGNETOMETER_IRON_CORRECT_AVERAGE_UNIT_MACROS_SVH

`ifndef SYNTH
`define MICA_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mica assertion failed");
`define MICA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mica assertion failed");
`else
`define MICA_ASSERT_IMPL(lbl, ante, cons)
`define MICA_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

FILE: hdl/mica_pkg.sv
// Shared types and codes for the magnetometer iron correction and averaging unit.
// No dependencies; used by every module of the unit.
package mica_pkg;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 48;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OFFSET_X = 3'd0,
    CFG_OFFSET_Y = 3'd1,
    CFG_OFFSET_Z = 3'd2,
    CFG_ROW_X    = 3'd3,
    CFG_ROW_Y    = 3'd4,
    CFG_ROW_Z    = 3'd5,
    CFG_FMIN     = 3'd6,
    CFG_FMAX     = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic signed [15:0] raw_x;
    logic signed [15:0] raw_y;
    logic signed [15:0] raw_z;
  } in_t;

  typedef struct packed {
    logic signed [15:0] avg_x;
    logic signed [15:0] avg_y;
    logic signed [15:0] avg_z;
    logic               fresh;
    logic               rejected;
  } out_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } vec3_t;

  typedef struct packed {
    logic signed [16:0] x;
    logic signed [16:0] y;
    logic signed [16:0] z;
  } hvec_t;

  typedef struct packed {
    logic signed [21:0] x;
    logic signed [21:0] y;
    logic signed [21:0] z;
  } sum3_t;

endpackage

FILE: hdl/mica_matmul.sv
// Bit-serial soft-iron matrix multiply with rounding and saturation to 16 bits.
// Depends on mica_pkg for the vector types.
module mica_matmul (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  mica_pkg::hvec_t   h,
  input  logic [47:0]       row_x,
  input  logic [47:0]       row_y,
  input  logic [47:0]       row_z,
  output logic              done,
  output mica_pkg::vec3_t   corr
);

  localparam int AW = 35;
  localparam int LAST = 16;

  mica_pkg::hvec_t       sh_r;
  logic [4:0]            cnt_r;
  logic                  busy_r;
  logic                  rnd_r;
  logic                  done_r;
  logic signed [AW-1:0]  acc_x_r, acc_y_r, acc_z_r;
  logic signed [AW-1:0]  acc_x_nxt, acc_y_nxt, acc_z_nxt;
  mica_pkg::vec3_t       corr_r;
  logic                  first;

  function automatic logic signed [AW-1:0] row_step(
    input logic signed [AW-1:0] acc,
    input logic [47:0]          row,
    input logic                 bx,
    input logic                 by,
    input logic                 bz,
    input logic                 neg
  );
    logic signed [AW-1:0] t;
    t = '0;
    if (bx) t = t + AW'($signed(row[47:32]));
    if (by) t = t + AW'($signed(row[31:16]));
    if (bz) t = t + AW'($signed(row[15:0]));
    if (neg) return (acc <<< 1) - t;
    return (acc <<< 1) + t;
  endfunction

  function automatic logic signed [15:0] round_sat(input logic signed [AW-1:0] p);
    logic signed [AW-1:0] s;
    logic signed [AW-14:0] q;
    s = p + AW'(4096);
    q = $signed(s[AW-1:13]);
    if (q > (AW-13)'(32767)) return 16'sh7fff;
    if (q < (AW-13)'(-32768)) return 16'sh8000;
    return $signed(q[15:0]);
  endfunction

  // The sign bit is consumed first and carries negative weight.
  assign first = (cnt_r == 5'd0);

  always_comb begin
    acc_x_nxt = row_step(acc_x_r, row_x, sh_r.x[16], sh_r.y[16], sh_r.z[16], first);
    acc_y_nxt = row_step(acc_y_r, row_y, sh_r.x[16], sh_r.y[16], sh_r.z[16], first);
    acc_z_nxt = row_step(acc_z_r, row_z, sh_r.x[16], sh_r.y[16], sh_r.z[16], first);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      rnd_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'(LAST)) begin
          busy_r <= 1'b0;
          rnd_r  <= 1'b1;
        end
      end
      if (rnd_r) begin
        rnd_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh_r    <= h;
      acc_x_r <= '0;
      acc_y_r <= '0;
      acc_z_r <= '0;
    end else if (busy_r) begin
      sh_r.x  <= {sh_r.x[15:0], 1'b0};
      sh_r.y  <= {sh_r.y[15:0], 1'b0};
      sh_r.z  <= {sh_r.z[15:0], 1'b0};
      acc_x_r <= acc_x_nxt;
      acc_y_r <= acc_y_nxt;
      acc_z_r <= acc_z_nxt;
    end
    if (rnd_r) begin
      corr_r.x <= round_sat(acc_x_r);
      corr_r.y <= round_sat(acc_y_r);
      corr_r.z <= round_sat(acc_z_r);
    end
  end

  assign done = done_r;
  assign corr = corr_r;

endmodule

FILE: hdl/mica_magsq.sv
// Bit-serial squared magnitude and squared window limits, with the window test.
// Depends on mica_pkg for the vector type.
module mica_magsq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  mica_pkg::vec3_t corr,
  input  logic [14:0]     fmin,
  input  logic [14:0]     fmax,
  output logic            done,
  output logic            rej
);

  localparam int MW = 33;
  localparam int LW = 30;

  mica_pkg::vec3_t       sh_r;
  logic [15:0]           smin_r, smax_r;
  logic signed [MW-1:0]  acc_m_r, acc_m_nxt;
  logic [LW-1:0]         acc_lo_r, acc_hi_r;
  logic [LW-1:0]         acc_lo_nxt, acc_hi_nxt;
  logic [3:0]            cnt_r;
  logic                  busy_r;
  logic                  fin_r;
  logic                  done_r;
  logic                  rej_r;
  logic signed [MW-1:0]  t;

  always_comb begin
    t = '0;
    if (sh_r.x[15]) t = t + MW'(corr.x);
    if (sh_r.y[15]) t = t + MW'(corr.y);
    if (sh_r.z[15]) t = t + MW'(corr.z);
    if (cnt_r == 4'd0) begin
      acc_m_nxt = -t;
    end else begin
      acc_m_nxt = (acc_m_r <<< 1) + t;
    end
    acc_lo_nxt = {acc_lo_r[LW-2:0], 1'b0} + (smin_r[15] ? LW'(fmin) : '0);
    acc_hi_nxt = {acc_hi_r[LW-2:0], 1'b0} + (smax_r[15] ? LW'(fmax) : '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 4'd1;
        if (cnt_r == 4'd15) begin
          busy_r <= 1'b0;
          fin_r  <= 1'b1;
        end
      end
      if (fin_r) begin
        fin_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh_r     <= corr;
      smin_r   <= {1'b0, fmin};
      smax_r   <= {1'b0, fmax};
      acc_m_r  <= '0;
      acc_lo_r <= '0;
      acc_hi_r <= '0;
    end else if (busy_r) begin
      sh_r.x   <= {sh_r.x[14:0], 1'b0};
      sh_r.y   <= {sh_r.y[14:0], 1'b0};
      sh_r.z   <= {sh_r.z[14:0], 1'b0};
      smin_r   <= {smin_r[14:0], 1'b0};
      smax_r   <= {smax_r[14:0], 1'b0};
      acc_m_r  <= acc_m_nxt;
      acc_lo_r <= acc_lo_nxt;
      acc_hi_r <= acc_hi_nxt;
    end
    if (fin_r) begin
      rej_r <= (acc_m_r < $signed({3'b000, acc_lo_r})) ||
               (acc_m_r > $signed({3'b000, acc_hi_r}));
    end
  end

  assign done = done_r;
  assign rej  = rej_r;

endmodule

FILE: hdl/mica_avgdiv.sv
// Bit-serial restoring divider that forms the three block averages, truncated toward zero.
// Depends on mica_pkg for the sum and vector types.
module mica_avgdiv #(
  parameter int BLOCK_SAMPLES = 8
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  mica_pkg::sum3_t sums,
  output logic            done,
  output mica_pkg::vec3_t avg
);

  localparam int RW = $clog2(BLOCK_SAMPLES) + 1;
  localparam int SW = 22;

  logic [SW-1:0]   x_r   [3];
  logic [RW-1:0]   rem_r [3];
  logic            neg_r [3];
  logic [SW-1:0]   x_nxt   [3];
  logic [RW-1:0]   rem_nxt [3];
  logic [SW-1:0]   ld_x    [3];
  logic            ld_neg  [3];
  logic [RW:0]     rem_sh  [3];
  logic [4:0]      cnt_r;
  logic            busy_r;
  logic            fin_r;
  logic            done_r;
  mica_pkg::vec3_t avg_r;

  always_comb begin
    ld_neg[0] = sums.x[SW-1];
    ld_neg[1] = sums.y[SW-1];
    ld_neg[2] = sums.z[SW-1];
    ld_x[0]   = ld_neg[0] ? SW'(-sums.x) : SW'(sums.x);
    ld_x[1]   = ld_neg[1] ? SW'(-sums.y) : SW'(sums.y);
    ld_x[2]   = ld_neg[2] ? SW'(-sums.z) : SW'(sums.z);
    for (int i = 0; i < 3; i++) begin
      rem_sh[i] = {rem_r[i], x_r[i][SW-1]};
      if (rem_sh[i] >= (RW+1)'(BLOCK_SAMPLES)) begin
        rem_nxt[i] = RW'(rem_sh[i] - (RW+1)'(BLOCK_SAMPLES));
        x_nxt[i]   = {x_r[i][SW-2:0], 1'b1};
      end else begin
        rem_nxt[i] = RW'(rem_sh[i]);
        x_nxt[i]   = {x_r[i][SW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'(SW - 1)) begin
          busy_r <= 1'b0;
          fin_r  <= 1'b1;
        end
      end
      if (fin_r) begin
        fin_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (start) begin
        x_r[i]   <= ld_x[i];
        rem_r[i] <= '0;
        neg_r[i] <= ld_neg[i];
      end else if (busy_r) begin
        x_r[i]   <= x_nxt[i];
        rem_r[i] <= rem_nxt[i];
      end
    end
    if (fin_r) begin
      avg_r.x <= neg_r[0] ? 16'(-x_r[0]) : x_r[0][15:0];
      avg_r.y <= neg_r[1] ? 16'(-x_r[1]) : x_r[1][15:0];
      avg_r.z <= neg_r[2] ? 16'(-x_r[2]) : x_r[2][15:0];
    end
  end

  assign done = done_r;
  assign avg  = avg_r;

endmodule

FILE: hdl/magnetometer_iron_correct_average_unit.sv
// Top level of the magnetometer hard/soft-iron correction and block averaging unit.
// Depends on mica_pkg, mica_matmul, mica_magsq, mica_avgdiv and the macros header.
//
// One sample is processed at a time and each produces exactly one result transfer. A sample
// occupies the unit for 17 steps of the bit-serial matrix multiply and 16 steps of the bit-serial
// magnitude square and, when it closes a block, 22 more steps of the serial divider before the
// next sample can be taken. A finished result waits in the output register, so the next sample
// may be taken while it is still unread. Configuration writes are accepted in every cycle and
// must only be issued while no sample is in flight.
`include "magnetometer_iron_correct_average_unit_macros.svh"

module magnetometer_iron_correct_average_unit #(
  parameter int BLOCK_SAMPLES = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  mica_pkg::in_t                       in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output mica_pkg::out_t                      out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mica_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mica_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int CW = $clog2(BLOCK_SAMPLES + 1);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL  = 5'b00010,
    ST_MAG  = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_OUT  = 5'b10000
  } state_t;

  state_t            state_r, state_nxt;
  logic signed [15:0] off_x_r, off_y_r, off_z_r;
  logic [47:0]       row_x_r, row_y_r, row_z_r;
  logic [14:0]       fmin_r, fmax_r;
  mica_pkg::sum3_t   sum_r, sum_nxt, sum_add;
  logic [CW-1:0]     cnt_r, cnt_nxt, cnt_inc;
  mica_pkg::vec3_t   good_r, good_nxt, add;
  mica_pkg::vec3_t   held_r, held_nxt;
  logic              fresh_r, fresh_nxt;
  logic              rej_r, rej_nxt;
  logic              out_valid_r, out_valid_nxt;
  mica_pkg::out_t    out_data_r;
  logic              out_load;
  logic              in_xfer;
  mica_pkg::hvec_t   hdiff;
  logic              mm_done;
  mica_pkg::vec3_t   corr;
  logic              mg_start, mg_done, mg_rej;
  logic              dv_start, dv_done;
  mica_pkg::vec3_t   dv_avg;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign hdiff.x = {in_data.raw_x[15], in_data.raw_x} - {off_x_r[15], off_x_r};
  assign hdiff.y = {in_data.raw_y[15], in_data.raw_y} - {off_y_r[15], off_y_r};
  assign hdiff.z = {in_data.raw_z[15], in_data.raw_z} - {off_z_r[15], off_z_r};

  mica_matmul u_matmul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (in_xfer),
    .h     (hdiff),
    .row_x (row_x_r),
    .row_y (row_y_r),
    .row_z (row_z_r),
    .done  (mm_done),
    .corr  (corr)
  );

  mica_magsq u_magsq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mg_start),
    .corr  (corr),
    .fmin  (fmin_r),
    .fmax  (fmax_r),
    .done  (mg_done),
    .rej   (mg_rej)
  );

  mica_avgdiv #(
    .BLOCK_SAMPLES (BLOCK_SAMPLES)
  ) u_avgdiv (
    .clk   (clk),
    .rst_n (rst_n),
    .start (dv_start),
    .sums  (sum_add),
    .done  (dv_done),
    .avg   (dv_avg)
  );

  always_comb begin
    add       = mg_rej ? good_r : corr;
    sum_add.x = sum_r.x + {{6{add.x[15]}}, add.x};
    sum_add.y = sum_r.y + {{6{add.y[15]}}, add.y};
    sum_add.z = sum_r.z + {{6{add.z[15]}}, add.z};
    cnt_inc   = cnt_r + CW'(1);
  end

  always_comb begin
    state_nxt = state_r;
    sum_nxt   = sum_r;
    cnt_nxt   = cnt_r;
    good_nxt  = good_r;
    held_nxt  = held_r;
    fresh_nxt = fresh_r;
    rej_nxt   = rej_r;
    mg_start  = 1'b0;
    dv_start  = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_MUL;
      end
      ST_MUL: begin
        if (mm_done) begin
          mg_start  = 1'b1;
          state_nxt = ST_MAG;
        end
      end
      ST_MAG: begin
        if (mg_done) begin
          rej_nxt = mg_rej;
          if (!mg_rej) good_nxt = corr;
          if (cnt_inc == CW'(BLOCK_SAMPLES)) begin
            dv_start  = 1'b1;
            sum_nxt   = '0;
            cnt_nxt   = '0;
            fresh_nxt = 1'b1;
            state_nxt = ST_DIV;
          end else begin
            sum_nxt   = sum_add;
            cnt_nxt   = cnt_inc;
            fresh_nxt = 1'b0;
            state_nxt = ST_OUT;
          end
        end
      end
      ST_DIV: begin
        if (dv_done) begin
          held_nxt  = dv_avg;
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    out_valid_nxt = out_load || (out_valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sum_r       <= '0;
      cnt_r       <= '0;
      good_r      <= '0;
      held_r      <= '0;
      fresh_r     <= 1'b0;
      rej_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sum_r       <= sum_nxt;
      cnt_r       <= cnt_nxt;
      good_r      <= good_nxt;
      held_r      <= held_nxt;
      fresh_r     <= fresh_nxt;
      rej_r       <= rej_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r.avg_x    <= held_r.x;
      out_data_r.avg_y    <= held_r.y;
      out_data_r.avg_z    <= held_r.z;
      out_data_r.fresh    <= fresh_r;
      out_data_r.rejected <= rej_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_x_r <= '0;
      off_y_r <= '0;
      off_z_r <= '0;
      row_x_r <= 48'h2000_0000_0000;
      row_y_r <= 48'h0000_2000_0000;
      row_z_r <= 48'h0000_0000_2000;
      fmin_r  <= '0;
      fmax_r  <= 15'h7fff;
    end else if (cfg_valid && cfg_ready) begin
      case (mica_pkg::cfg_idx_t'(cfg_index))
        mica_pkg::CFG_OFFSET_X: off_x_r <= cfg_data[15:0];
        mica_pkg::CFG_OFFSET_Y: off_y_r <= cfg_data[15:0];
        mica_pkg::CFG_OFFSET_Z: off_z_r <= cfg_data[15:0];
        mica_pkg::CFG_ROW_X:    row_x_r <= cfg_data;
        mica_pkg::CFG_ROW_Y:    row_y_r <= cfg_data;
        mica_pkg::CFG_ROW_Z:    row_z_r <= cfg_data;
        mica_pkg::CFG_FMIN:     fmin_r  <= cfg_data[14:0];
        mica_pkg::CFG_FMAX:     fmax_r  <= cfg_data[14:0];
        default: begin
        end
      endcase
    end
  end

  `MICA_ASSERT_NEXT(a_xfer_starts_mul, in_valid && in_ready, state_r == ST_MUL)
  `MICA_ASSERT_IMPL(a_mul_done_waited, mm_done, state_r == ST_MUL)
  `MICA_ASSERT_IMPL(a_div_only_on_block, dv_done, state_r == ST_DIV && fresh_r)
  `MICA_ASSERT_IMPL(a_count_in_block, 1'b1, cnt_r < CW'(BLOCK_SAMPLES))

endmodule

FILE: verif/tb_top.sv
// Self-checking testbench for magnetometer_iron_correct_average_unit.
// Depends on mica_pkg and the unit's RTL; predicts every result transfer in-house and
// compares it field by field while both channels idle and stall at random.
module tb_top;

  localparam int AVG_BLOCK = 8;
  localparam int SETTLE_CYCLES = 80;
  localparam int LONG_HOLD = 400;
  localparam int WATCHDOG_LIMIT = 10000;
  localparam int RANDOM_PHASES = 15;
  localparam int PHASE_SAMPLES = 90;

  typedef logic [mica_pkg::CFG_DATA_W-1:0] reg_words_t [8];

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  mica_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  mica_pkg::out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [mica_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [mica_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  logic signed [15:0] cal_offset [3] = '{16'sd0, 16'sd0, 16'sd0};
  logic [47:0] cal_row [3] = '{48'h2000_0000_0000, 48'h0000_2000_0000, 48'h0000_0000_2000};
  logic [14:0] win_min = 15'd0;
  logic [14:0] win_max = 15'h7FFF;
  mica_pkg::sum3_t block_sum = '0;
  int block_fill = 0;
  mica_pkg::vec3_t last_good = '0;
  mica_pkg::vec3_t held_avg = '0;

  mica_pkg::out_t pending_averages [$];
  int mismatch_count = 0;
  int samples_sent = 0;
  int results_checked = 0;
  int fresh_seen = 0;
  int rejected_seen = 0;
  int settings_used = 1;
  int burst_left = 0;
  int hold_requests = 0;
  int holds_served = 0;
  int idle_cycles = 0;

  magnetometer_iron_correct_average_unit #(
    .BLOCK_SAMPLES(AVG_BLOCK)
  ) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  function automatic logic signed [15:0] soft_iron_axis(logic [47:0] row, longint hx, longint hy,
                                                        longint hz);
    longint acc;
    longint q;
    acc = longint'($signed(row[47:32])) * hx + longint'($signed(row[31:16])) * hy +
          longint'($signed(row[15:0])) * hz + 4096;
    q = acc >>> 13;
    if (q > 32767) begin
      q = 32767;
    end else if (q < -32768) begin
      q = -32768;
    end
    return q[15:0];
  endfunction

  function automatic mica_pkg::out_t predict_corrected_average(mica_pkg::in_t s);
    longint hx;
    longint hy;
    longint hz;
    longint mag2;
    mica_pkg::vec3_t c;
    mica_pkg::out_t r;
    hx = longint'(s.raw_x) - longint'(cal_offset[0]);
    hy = longint'(s.raw_y) - longint'(cal_offset[1]);
    hz = longint'(s.raw_z) - longint'(cal_offset[2]);
    c.x = soft_iron_axis(cal_row[0], hx, hy, hz);
    c.y = soft_iron_axis(cal_row[1], hx, hy, hz);
    c.z = soft_iron_axis(cal_row[2], hx, hy, hz);
    mag2 = longint'(c.x) * longint'(c.x) + longint'(c.y) * longint'(c.y) +
           longint'(c.z) * longint'(c.z);
    r.rejected = (mag2 < longint'(win_min) * longint'(win_min)) ||
                 (mag2 > longint'(win_max) * longint'(win_max));
    if (!r.rejected) begin
      last_good = c;
    end
    block_sum.x = block_sum.x + last_good.x;
    block_sum.y = block_sum.y + last_good.y;
    block_sum.z = block_sum.z + last_good.z;
    block_fill++;
    r.fresh = 1'b0;
    if (block_fill >= AVG_BLOCK) begin
      held_avg.x = block_sum.x / AVG_BLOCK;
      held_avg.y = block_sum.y / AVG_BLOCK;
      held_avg.z = block_sum.z / AVG_BLOCK;
      block_sum = '0;
      block_fill = 0;
      r.fresh = 1'b1;
    end
    r.avg_x = held_avg.x;
    r.avg_y = held_avg.y;
    r.avg_z = held_avg.z;
    return r;
  endfunction

  function automatic mica_pkg::in_t sample_of(int x, int y, int z);
    mica_pkg::in_t s;
    s.raw_x = x[15:0];
    s.raw_y = y[15:0];
    s.raw_z = z[15:0];
    return s;
  endfunction

  function automatic mica_pkg::in_t random_sample();
    mica_pkg::in_t s;
    if ($urandom_range(0, 99) < 65) begin
      s.raw_x = cal_offset[0] + 16'(int'($urandom_range(0, 8000)) - 4000);
      s.raw_y = cal_offset[1] + 16'(int'($urandom_range(0, 8000)) - 4000);
      s.raw_z = cal_offset[2] + 16'(int'($urandom_range(0, 8000)) - 4000);
    end else begin
      s = mica_pkg::in_t'(48'({$urandom(), $urandom()}));
    end
    return s;
  endfunction

  function automatic logic [15:0] random_coef(bit diag);
    if ($urandom_range(0, 4) == 0) begin
      return 16'($urandom());
    end
    if (diag) begin
      return 16'(8192 + int'($urandom_range(0, 4096)) - 2048);
    end
    return 16'(int'($urandom_range(0, 2048)) - 1024);
  endfunction

  function automatic logic [15:0] random_offset();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2, 3, 4: return 16'($urandom());
      default: return 16'(int'($urandom_range(0, 4000)) - 2000);
    endcase
  endfunction

  function automatic void load_defaults(output reg_words_t w);
    w[mica_pkg::CFG_OFFSET_X] = '0;
    w[mica_pkg::CFG_OFFSET_Y] = '0;
    w[mica_pkg::CFG_OFFSET_Z] = '0;
    w[mica_pkg::CFG_ROW_X] = 48'h2000_0000_0000;
    w[mica_pkg::CFG_ROW_Y] = 48'h0000_2000_0000;
    w[mica_pkg::CFG_ROW_Z] = 48'h0000_0000_2000;
    w[mica_pkg::CFG_FMIN] = 48'd0;
    w[mica_pkg::CFG_FMAX] = 48'h7FFF;
  endfunction

  function automatic void random_words(output reg_words_t w);
    int lo;
    int hi;
    w[mica_pkg::CFG_OFFSET_X] = {$urandom(), random_offset()};
    w[mica_pkg::CFG_OFFSET_Y] = {$urandom(), random_offset()};
    w[mica_pkg::CFG_OFFSET_Z] = {$urandom(), random_offset()};
    w[mica_pkg::CFG_ROW_X] = {random_coef(1'b1), random_coef(1'b0), random_coef(1'b0)};
    w[mica_pkg::CFG_ROW_Y] = {random_coef(1'b0), random_coef(1'b1), random_coef(1'b0)};
    w[mica_pkg::CFG_ROW_Z] = {random_coef(1'b0), random_coef(1'b0), random_coef(1'b1)};
    case ($urandom_range(0, 9))
      0: begin
        lo = $urandom_range(1, 32767);
        hi = $urandom_range(0, lo - 1);
      end
      1: begin
        lo = 0;
        hi = 32767;
      end
      default: begin
        lo = $urandom_range(0, 12000);
        hi = lo + $urandom_range(0, 32767 - lo);
      end
    endcase
    w[mica_pkg::CFG_FMIN] = {$urandom(), 1'($urandom()), 15'(lo)};
    w[mica_pkg::CFG_FMAX] = {$urandom(), 1'($urandom()), 15'(hi)};
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    mismatch_count++;
    $display("Mismatch on result %0d, %s: got %0d, expected %0d",
             results_checked, what, got, want);
  endtask

  task automatic write_reg(mica_pkg::cfg_idx_t idx, logic [mica_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      mica_pkg::CFG_OFFSET_X: cal_offset[0] = data[15:0];
      mica_pkg::CFG_OFFSET_Y: cal_offset[1] = data[15:0];
      mica_pkg::CFG_OFFSET_Z: cal_offset[2] = data[15:0];
      mica_pkg::CFG_ROW_X: cal_row[0] = data[47:0];
      mica_pkg::CFG_ROW_Y: cal_row[1] = data[47:0];
      mica_pkg::CFG_ROW_Z: cal_row[2] = data[47:0];
      mica_pkg::CFG_FMIN: win_min = data[14:0];
      mica_pkg::CFG_FMAX: win_max = data[14:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic program_settings(reg_words_t w);
    for (int i = 0; i < 8; i++) begin
      write_reg(mica_pkg::cfg_idx_t'(i), w[i]);
    end
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  task automatic offer_sample(mica_pkg::in_t s, bit steady);
    int gap;
    if (!steady && burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 80);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data <= s;
    do @(posedge clk); while (!in_ready);
    pending_averages.push_back(predict_corrected_average(s));
    samples_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending_averages.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic test_default_window();
    offer_sample(sample_of(-32768, -32768, -32768), 1'b0);
    offer_sample(sample_of(0, 0, 0), 1'b0);
    offer_sample(sample_of(32767, 0, 0), 1'b0);
    offer_sample(sample_of(32767, 1, 0), 1'b0);
    offer_sample(sample_of(-32768, 0, 0), 1'b0);
    offer_sample(sample_of(100, -200, 300), 1'b0);
    offer_sample(sample_of(-1, -1, -1), 1'b0);
    offer_sample(sample_of(32767, 32767, 32767), 1'b0);
    wait_drained();
  endtask

  task automatic test_saturation_extremes();
    reg_words_t w;
    load_defaults(w);
    w[mica_pkg::CFG_OFFSET_X] = 48'h8000;
    w[mica_pkg::CFG_OFFSET_Y] = 48'h7FFF;
    w[mica_pkg::CFG_OFFSET_Z] = 48'hFFFF;
    w[mica_pkg::CFG_ROW_X] = {16'h7FFF, 16'h7FFF, 16'h7FFF};
    w[mica_pkg::CFG_ROW_Y] = {16'h8000, 16'h8000, 16'h8000};
    w[mica_pkg::CFG_ROW_Z] = {16'h0000, 16'h2000, 16'h8001};
    program_settings(w);
    offer_sample(sample_of(32767, -32768, 0), 1'b0);
    offer_sample(sample_of(-32768, 32767, -1), 1'b0);
    offer_sample(sample_of(32767, 32767, 32767), 1'b0);
    offer_sample(sample_of(-32768, -32768, -32768), 1'b0);
    offer_sample(sample_of(-32767, 32766, 0), 1'b0);
    offer_sample(sample_of(-1, 1, 32767), 1'b0);
    offer_sample(sample_of(0, 0, 0), 1'b0);
    offer_sample(sample_of(-32768, 32767, -2), 1'b0);
    wait_drained();
  endtask

  task automatic test_empty_window();
    reg_words_t w;
    load_defaults(w);
    w[mica_pkg::CFG_FMIN] = 48'd1000;
    w[mica_pkg::CFG_FMAX] = 48'd999;
    program_settings(w);
    offer_sample(sample_of(0, 0, 0), 1'b0);
    offer_sample(sample_of(999, 0, 0), 1'b0);
    offer_sample(sample_of(1000, 0, 0), 1'b0);
    offer_sample(sample_of(0, -1000, 0), 1'b0);
    offer_sample(sample_of(600, 600, 600), 1'b0);
    offer_sample(sample_of(-32768, 32767, 0), 1'b0);
    offer_sample(sample_of(12, -34, 56), 1'b0);
    offer_sample(sample_of(0, 0, 1000), 1'b0);
    wait_drained();
  endtask

  task automatic test_random_settings();
    reg_words_t w;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      random_words(w);
      program_settings(w);
      repeat (PHASE_SAMPLES) offer_sample(random_sample(), 1'b0);
      wait_drained();
    end
  endtask

  task automatic test_output_backpressure();
    reg_words_t w;
    load_defaults(w);
    w[mica_pkg::CFG_FMIN] = 48'd500;
    w[mica_pkg::CFG_FMAX] = 48'd3500;
    program_settings(w);
    hold_requests++;
    repeat (60) offer_sample(random_sample(), 1'b1);
    wait_drained();
  endtask

  initial begin : receiver_pattern
    int hold_left;
    int rx_cycle;
    logic rdy;
    hold_left = 0;
    rx_cycle = 0;
    forever begin
      @(negedge clk);
      rx_cycle++;
      if (hold_left == 0 && holds_served != hold_requests) begin
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
        if (hold_left == 0) begin
          holds_served++;
        end
      end else begin
        case ((rx_cycle / 150) % 4)
          0: rdy = 1'b1;
          1: rdy = 1'($urandom_range(0, 1));
          2: rdy = (rx_cycle % 7) < 3;
          default: rdy = $urandom_range(0, 9) != 0;
        endcase
      end
      out_ready <= rdy;
    end
  end

  always @(posedge clk) begin : check_results
    mica_pkg::out_t want;
    if (rst_n && out_valid && out_ready) begin
      results_checked++;
      if (out_data.fresh) begin
        fresh_seen++;
      end
      if (out_data.rejected) begin
        rejected_seen++;
      end
      if (pending_averages.size() == 0) begin
        report_mismatch("transfer with no result pending", 1, 0);
      end else begin
        want = pending_averages.pop_front();
        if (out_data.avg_x !== want.avg_x) report_mismatch("avg_x", out_data.avg_x, want.avg_x);
        if (out_data.avg_y !== want.avg_y) report_mismatch("avg_y", out_data.avg_y, want.avg_y);
        if (out_data.avg_z !== want.avg_z) report_mismatch("avg_z", out_data.avg_z, want.avg_z);
        if (out_data.fresh !== want.fresh) report_mismatch("fresh", out_data.fresh, want.fresh);
        if (out_data.rejected !== want.rejected) begin
          report_mismatch("rejected", out_data.rejected, want.rejected);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout after %0d cycles without a transfer", idle_cycles);
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_default_window();
    test_saturation_extremes();
    test_empty_window();
    test_random_settings();
    test_output_backpressure();
    wait_drained();
    $display("Run covered %0d samples under %0d register settings; %0d results checked.",
             samples_sent, settings_used, results_checked);
    $display("Results flagged rejected: %0d, completed blocks: %0d, long output hold-offs: %0d.",
             rejected_seen, fresh_seen, holds_served);
    if (mismatch_count == 0 && pending_averages.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
